>>> hdl/ffc_pkg.sv
`timescale 1ns / 1ps
// ffc_pkg: request/response payload types, format codes and stage records
// for the float format converter. No dependencies.
package ffc_pkg;

	localparam logic [1:0] FMT_SINGLE = 2'd0;
	localparam logic [1:0] FMT_DOUBLE = 2'd1;
	localparam logic [1:0] FMT_EXT    = 2'd2;

	localparam logic [1:0] CLS_ZERO = 2'd0;
	localparam logic [1:0] CLS_NORM = 2'd1;
	localparam logic [1:0] CLS_INF  = 2'd2;
	localparam logic [1:0] CLS_NAN  = 2'd3;

	localparam logic signed [15:0] SGL_BIAS = 16'sd127;
	localparam logic signed [15:0] SGL_EMIN = -16'sd126;
	localparam logic signed [15:0] DBL_BIAS = 16'sd1023;
	localparam logic signed [15:0] DBL_EMIN = -16'sd1022;
	localparam logic signed [15:0] EXT_BIAS = 16'sd16383;
	localparam logic signed [15:0] EXT_EMIN = -16'sd16382;

	localparam logic [7:0]  SGL_EALL = 8'hff;
	localparam logic [10:0] DBL_EALL = 11'h7ff;
	localparam logic [14:0] EXT_EALL = 15'h7fff;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  target_format;
		logic [63:0] in_mantissa;
		logic [15:0] in_sign_exponent;
	} ffc_req_t;

	typedef struct packed {
		logic [63:0] out_mantissa;
		logic [15:0] out_sign_exponent;
	} ffc_rsp_t;

	// Unpacked value after stage 1
	typedef struct packed {
		logic [1:0]         tgt;
		logic [1:0]         cls;
		logic               sign;
		logic signed [15:0] exp;
		logic [63:0]        sig;
	} ffc_unp_t;

	// Target-range decision after stage 2
	typedef struct packed {
		logic [1:0]  tgt;
		logic [1:0]  cls;
		logic        sign;
		logic [14:0] bexp;
		logic [62:0] frac;
		logic [7:0]  payload;
	} ffc_rng_t;

endpackage

>>> hdl/ffc_unpack.sv
`timescale 1ns / 1ps
// ffc_unpack: stage 1, splits a raw single/double/extended request into
// class, sign, unbiased exponent and 64-bit significand. Uses ffc_pkg.
module ffc_unpack (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  ffc_pkg::ffc_req_t req,
	output logic            valid_s1,
	output ffc_pkg::ffc_unp_t unp_s1
);
	import ffc_pkg::*;

	ffc_unp_t   u;
	logic [7:0]  s_e;
	logic [22:0] s_f;
	logic [10:0] d_e;
	logic [51:0] d_f;
	logic [14:0] x_e;

	always_comb begin
		s_e = req.in_mantissa[30:23];
		s_f = req.in_mantissa[22:0];
		d_e = req.in_mantissa[62:52];
		d_f = req.in_mantissa[51:0];
		x_e = req.in_sign_exponent[14:0];
		u.tgt  = req.target_format;
		u.cls  = CLS_ZERO;
		u.sign = 1'b0;
		u.exp  = '0;
		u.sig  = '0;
		unique case (req.kind)
			FMT_SINGLE: begin
				u.sign = req.in_mantissa[31];
				if (s_e == SGL_EALL) begin
					u.cls = (s_f == '0) ? CLS_INF : CLS_NAN;
					u.sig = {41'b0, 1'b0, s_f[21:0]};
				end else if (s_e != '0) begin
					u.cls = CLS_NORM;
					u.exp = $signed({8'b0, s_e}) - SGL_BIAS;
					u.sig = {1'b1, s_f, 40'b0};
				end
			end
			FMT_DOUBLE: begin
				u.sign = req.in_mantissa[63];
				if (d_e == DBL_EALL) begin
					u.cls = (d_f == '0) ? CLS_INF : CLS_NAN;
					u.sig = {12'b0, 1'b0, d_f[50:0]};
				end else if (d_e != '0) begin
					u.cls = CLS_NORM;
					u.exp = $signed({5'b0, d_e}) - DBL_BIAS;
					u.sig = {1'b1, d_f, 11'b0};
				end
			end
			default: begin
				// extended, and the unused selector code
				u.sign = req.in_sign_exponent[15];
				if (x_e == EXT_EALL) begin
					u.cls = (req.in_mantissa[62:0] == '0) ? CLS_INF : CLS_NAN;
					u.sig = {2'b0, req.in_mantissa[61:0]};
				end else if (x_e != '0 && req.in_mantissa[63]) begin
					u.cls = CLS_NORM;
					u.exp = $signed({1'b0, x_e}) - EXT_BIAS;
					u.sig = req.in_mantissa;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unp_s1 <= u;
		end
	end

endmodule

>>> hdl/ffc_range.sv
`timescale 1ns / 1ps
// ffc_range: stage 2, checks the exponent against the target range and
// forms the biased exponent and NaN payload. Uses ffc_pkg.
module ffc_range (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  ffc_pkg::ffc_unp_t unp,
	output logic            valid_s2,
	output ffc_pkg::ffc_rng_t rng_s2
);
	import ffc_pkg::*;

	ffc_rng_t           r;
	logic signed [15:0] bias;
	logic signed [15:0] emin;
	logic signed [15:0] biased;

	always_comb begin
		unique case (unp.tgt)
			FMT_SINGLE: begin
				bias = SGL_BIAS;
				emin = SGL_EMIN;
			end
			FMT_DOUBLE: begin
				bias = DBL_BIAS;
				emin = DBL_EMIN;
			end
			default: begin
				bias = EXT_BIAS;
				emin = EXT_EMIN;
			end
		endcase
		biased = unp.exp + bias;

		r.tgt     = unp.tgt;
		r.sign    = unp.sign;
		r.bexp    = biased[14:0];
		r.frac    = unp.sig[62:0];
		r.payload = (unp.sig[7:0] == '0) ? 8'd1 : unp.sig[7:0];
		// max exponent equals the bias for every target
		priority if (unp.cls == CLS_NAN) begin
			r.cls = CLS_NAN;
		end else if (unp.cls == CLS_INF || (unp.cls == CLS_NORM && unp.exp > bias)) begin
			r.cls = CLS_INF;
		end else if (unp.cls == CLS_NORM && unp.exp >= emin) begin
			r.cls = CLS_NORM;
		end else begin
			r.cls = CLS_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rng_s2 <= r;
		end
	end

endmodule

>>> hdl/ffc_pack.sv
`timescale 1ns / 1ps
// ffc_pack: stage 3, encodes the range-checked value in the target format
// into the output register. Uses ffc_pkg.
module ffc_pack (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  ffc_pkg::ffc_rng_t rng,
	output logic            valid_s3,
	output ffc_pkg::ffc_rsp_t rsp_s3
);
	import ffc_pkg::*;

	ffc_rsp_t o;

	always_comb begin
		o = '0;
		unique case (rng.tgt)
			FMT_SINGLE: begin
				o.out_mantissa[31] = rng.sign;
				unique case (rng.cls)
					CLS_NAN:  o.out_mantissa[30:0] = {SGL_EALL, 1'b1, 14'b0, rng.payload};
					CLS_INF:  o.out_mantissa[30:0] = {SGL_EALL, 23'b0};
					CLS_NORM: o.out_mantissa[30:0] = {rng.bexp[7:0], rng.frac[62:40]};
					default:  o.out_mantissa[30:0] = '0;
				endcase
			end
			FMT_DOUBLE: begin
				o.out_mantissa[63] = rng.sign;
				unique case (rng.cls)
					CLS_NAN:  o.out_mantissa[62:0] = {DBL_EALL, 1'b1, 43'b0, rng.payload};
					CLS_INF:  o.out_mantissa[62:0] = {DBL_EALL, 52'b0};
					CLS_NORM: o.out_mantissa[62:0] = {rng.bexp[10:0], rng.frac[62:11]};
					default:  o.out_mantissa[62:0] = '0;
				endcase
			end
			default: begin
				o.out_sign_exponent[15] = rng.sign;
				unique case (rng.cls)
					CLS_NAN: begin
						o.out_sign_exponent[14:0] = EXT_EALL;
						o.out_mantissa = {2'b11, 54'b0, rng.payload};
					end
					CLS_INF: begin
						o.out_sign_exponent[14:0] = EXT_EALL;
						o.out_mantissa = {1'b1, 63'b0};
					end
					CLS_NORM: begin
						o.out_sign_exponent[14:0] = rng.bexp;
						o.out_mantissa = {1'b1, rng.frac};
					end
					default: begin
						o.out_mantissa = '0;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s3 <= o;
		end
	end

endmodule

>>> hdl/float_format_converter_top.sv
`timescale 1ns / 1ps
// float_format_converter_top: single/double/extended format converter.
// A request passes the unpack, range and pack stage registers to its response.
// One request per cycle when not stalled; a stage register loads when empty or
// when the stage after it moves, so bubbles close up under a downstream stall.
// Reset clears the three stage valid bits; data registers are not reset.
module float_format_converter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  ffc_pkg::ffc_req_t src,
	output logic              dst_valid,
	input  logic              dst_stall,
	output ffc_pkg::ffc_rsp_t dst
);
	import ffc_pkg::*;

	logic     valid_s1;
	logic     valid_s2;
	logic     valid_s3;
	logic     en1;
	logic     en2;
	logic     en3;
	ffc_unp_t unp_s1;
	ffc_rng_t rng_s2;

	// advance a stage when it is empty or its contents move on
	assign en3       = !valid_s3 || !dst_stall;
	assign en2       = !valid_s2 || en3;
	assign en1       = !valid_s1 || en2;
	assign src_stall = !en1;
	assign dst_valid = valid_s3;

	ffc_unpack u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.valid_in (src_valid),
		.req      (src),
		.valid_s1 (valid_s1),
		.unp_s1   (unp_s1)
	);

	ffc_range u_range (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_in (valid_s1),
		.unp      (unp_s1),
		.valid_s2 (valid_s2),
		.rng_s2   (rng_s2)
	);

	ffc_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_in (valid_s2),
		.rng      (rng_s2),
		.valid_s3 (valid_s3),
		.rsp_s3   (dst)
	);

endmodule

>>> tb/float_format_converter_top_tb.sv
`timescale 1ns / 1ps
// float_format_converter_top_tb: checks single/double/extended conversion against
// a behavioral predictor through a response scoreboard. Depends on ffc_pkg and the top.
module float_format_converter_top_tb;
	import ffc_pkg::*;

	// Selector value three decodes and encodes as extended
	localparam logic [1:0] FMT_EXT_ALT = 2'd3;

	class conversion_scoreboard;
		ffc_rsp_t pending_results[$];
		int mismatches = 0;

		task report(string msg);
			mismatches++;
			$display("%0t: %s", $time, msg);
		endtask

		static function ffc_rsp_t convert_value(ffc_req_t r);
			logic [1:0]  cls;
			logic        sgn;
			int          e;
			logic [63:0] sig;
			logic [63:0] m;
			logic [14:0] xe;
			logic [31:0] w;
			logic [7:0]  pay;
			ffc_rsp_t    o;
			m = r.in_mantissa;
			sig = '0;
			e = 0;
			case (r.kind)
				FMT_SINGLE: begin
					w = m[31:0];
					sgn = w[31];
					if (w[30:23] == SGL_EALL) begin
						cls = (w[22:0] == '0) ? CLS_INF : CLS_NAN;
						sig = {42'b0, w[21:0]};
					end else if (w[30:23] == '0) begin
						cls = CLS_ZERO;
					end else begin
						cls = CLS_NORM;
						e = int'(w[30:23]) - int'(SGL_BIAS);
						sig = {1'b1, w[22:0], 40'b0};
					end
				end
				FMT_DOUBLE: begin
					sgn = m[63];
					if (m[62:52] == DBL_EALL) begin
						cls = (m[51:0] == '0) ? CLS_INF : CLS_NAN;
						sig = {13'b0, m[50:0]};
					end else if (m[62:52] == '0) begin
						cls = CLS_ZERO;
					end else begin
						cls = CLS_NORM;
						e = int'(m[62:52]) - int'(DBL_BIAS);
						sig = {1'b1, m[51:0], 11'b0};
					end
				end
				default: begin
					xe = r.in_sign_exponent[14:0];
					sgn = r.in_sign_exponent[15];
					if (xe == EXT_EALL) begin
						// explicit one is don't-care here; drop it and the quiet bit
						cls = (m[62:0] == '0) ? CLS_INF : CLS_NAN;
						sig = {2'b0, m[61:0]};
					end else if (xe == '0 || !m[63]) begin
						cls = CLS_ZERO;
					end else begin
						cls = CLS_NORM;
						e = int'(xe) - int'(EXT_BIAS);
						sig = m;
					end
				end
			endcase
			pay = (sig[7:0] == '0) ? 8'd1 : sig[7:0];

			o = '0;
			case (r.target_format)
				FMT_SINGLE: begin
					w = {sgn, 31'b0};
					if (cls == CLS_NAN) begin
						w[30:0] = {SGL_EALL, 1'b1, 14'b0, pay};
					end else if (cls == CLS_INF || (cls == CLS_NORM && e > SGL_BIAS)) begin
						w[30:23] = SGL_EALL;
					end else if (cls == CLS_NORM && e >= SGL_EMIN) begin
						w[30:23] = 8'(e + SGL_BIAS);
						w[22:0] = sig[62:40];
					end
					o.out_mantissa = {32'b0, w};
				end
				FMT_DOUBLE: begin
					o.out_mantissa[63] = sgn;
					if (cls == CLS_NAN) begin
						o.out_mantissa[62:0] = {DBL_EALL, 1'b1, 43'b0, pay};
					end else if (cls == CLS_INF || (cls == CLS_NORM && e > DBL_BIAS)) begin
						o.out_mantissa[62:52] = DBL_EALL;
					end else if (cls == CLS_NORM && e >= DBL_EMIN) begin
						o.out_mantissa[62:52] = 11'(e + DBL_BIAS);
						o.out_mantissa[51:0] = sig[62:11];
					end
				end
				default: begin
					o.out_sign_exponent[15] = sgn;
					if (cls == CLS_NAN) begin
						o.out_sign_exponent[14:0] = EXT_EALL;
						o.out_mantissa = {2'b11, 54'b0, pay};
					end else if (cls == CLS_INF || (cls == CLS_NORM && e > EXT_BIAS)) begin
						o.out_sign_exponent[14:0] = EXT_EALL;
						o.out_mantissa = {1'b1, 63'b0};
					end else if (cls == CLS_NORM && e >= EXT_EMIN) begin
						o.out_sign_exponent[14:0] = 15'(e + EXT_BIAS);
						o.out_mantissa = sig;
					end
				end
			endcase
			return o;
		endfunction

		function void note_request(ffc_req_t r);
			pending_results.push_back(convert_value(r));
		endfunction

		task check_response(ffc_rsp_t got);
			ffc_rsp_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("response with no request outstanding: %h", got));
			end else begin
				want = pending_results.pop_front();
				if (got.out_mantissa !== want.out_mantissa)
					report($sformatf("out_mantissa got %h, expected %h",
						got.out_mantissa, want.out_mantissa));
				if (got.out_sign_exponent !== want.out_sign_exponent)
					report($sformatf("out_sign_exponent got %h, expected %h",
						got.out_sign_exponent, want.out_sign_exponent));
			end
		endtask
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     src_valid = 1'b0;
	logic     src_stall;
	ffc_req_t src = '0;
	logic     dst_valid;
	logic     dst_stall = 1'b0;
	ffc_rsp_t dst;

	conversion_scoreboard sb = new();
	bit steady = 1'b0;
	int stall_left = 0;

	float_format_converter_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src(src),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst(dst)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		else if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic ffc_req_t make_request(logic [1:0] kind, logic [1:0] tgt,
			logic [63:0] m, logic [15:0] se);
		ffc_req_t r;
		r.kind = kind;
		r.target_format = tgt;
		r.in_mantissa = m;
		r.in_sign_exponent = se;
		return r;
	endfunction

	// Exponent field: zero, all ones, near either range edge, or anywhere
	function automatic int pick_exponent(int emax, int edge_lo, int edge_hi);
		int p;
		p = $urandom_range(0, 9);
		if (p == 0)
			return 0;
		else if (p == 1)
			return emax;
		else if (p < 4)
			return $urandom_range(edge_lo - 2, edge_lo + 2);
		else if (p < 6)
			return $urandom_range(edge_hi - 2, edge_hi + 2);
		return $urandom_range(0, emax);
	endfunction

	// Fraction: zero, all ones, low byte cleared (empty NaN payload), or random
	function automatic logic [63:0] shape_fraction(logic [63:0] x);
		int p;
		p = $urandom_range(0, 7);
		if (p == 0)
			return '0;
		else if (p == 1)
			return '1;
		else if (p == 2)
			return {x[63:8], 8'b0};
		return x;
	endfunction

	function automatic ffc_req_t random_request();
		ffc_req_t    r;
		logic [63:0] m;
		logic [63:0] f;
		r.kind = 2'($urandom_range(0, 3));
		r.target_format = 2'($urandom_range(0, 3));
		r.in_sign_exponent = 16'($urandom);
		m = {$urandom, $urandom};
		f = shape_fraction({$urandom, $urandom});
		case (r.kind)
			FMT_SINGLE: begin
				m[30:23] = 8'(pick_exponent(255, 1, 254));
				m[22:0] = f[22:0];
			end
			FMT_DOUBLE: begin
				m[62:52] = 11'(pick_exponent(2047, 897, 1150));
				m[51:0] = f[51:0];
			end
			default: begin
				if ($urandom_range(0, 1))
					r.in_sign_exponent[14:0] = 15'(pick_exponent(32767, 15361, 17406));
				else
					r.in_sign_exponent[14:0] = 15'(pick_exponent(32767, 16257, 16510));
				m[63] = ($urandom_range(0, 3) != 0);
				m[62:0] = f[62:0];
			end
		endcase
		r.in_mantissa = m;
		return r;
	endfunction

	// Call at a falling edge; returns at the falling edge after acceptance
	task send_request(ffc_req_t r);
		int gap;
		gap = steady ? 0 : gap_length();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		src <= r;
		do
			@(posedge clk);
		while (src_stall);
		sb.note_request(r);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (steady)
			stall_left = 0;
		else if (stall_left == 0)
			stall_left = gap_length();
		dst_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall)
			sb.check_response(dst);
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// zeros, denormals, extremes, infinities and NaNs of each source
		send_request(make_request(FMT_SINGLE, FMT_EXT, 64'h0, 16'h0));
		send_request(make_request(FMT_SINGLE, FMT_DOUBLE, 64'h8000_0000, 16'hffff));
		send_request(make_request(FMT_SINGLE, FMT_SINGLE, 64'h0000_0001, 16'h0));
		send_request(make_request(FMT_SINGLE, FMT_DOUBLE, 64'h7f7f_ffff, 16'h0));
		send_request(make_request(FMT_SINGLE, FMT_EXT, 64'h0080_0000, 16'h0));
		send_request(make_request(FMT_SINGLE, FMT_EXT, 64'h7f80_0000, 16'h0));
		send_request(make_request(FMT_SINGLE, FMT_DOUBLE, 64'hffc0_0000, 16'h0));
		send_request(make_request(FMT_SINGLE, FMT_SINGLE, 64'hffff_ffff_7f80_00ab, 16'h0));
		send_request(make_request(FMT_DOUBLE, FMT_SINGLE, 64'h7fef_ffff_ffff_ffff, 16'h0));
		send_request(make_request(FMT_DOUBLE, FMT_SINGLE, 64'h0010_0000_0000_0000, 16'h0));
		send_request(make_request(FMT_DOUBLE, FMT_EXT, 64'hfff0_0000_0000_0000, 16'h0));
		send_request(make_request(FMT_DOUBLE, FMT_SINGLE, 64'h7ff8_0000_0000_0000, 16'h0));
		send_request(make_request(FMT_DOUBLE, FMT_DOUBLE, 64'h000f_ffff_ffff_ffff, 16'h0));
		send_request(make_request(FMT_DOUBLE, FMT_EXT, 64'h3ff0_0000_0000_0000, 16'h0));
		send_request(make_request(FMT_EXT, FMT_DOUBLE, 64'hffff_ffff_ffff_ffff, 16'h8000));
		// unnormal: explicit one clear with an ordinary exponent
		send_request(make_request(FMT_EXT, FMT_SINGLE, 64'h7fff_ffff_ffff_ffff, 16'h3fff));
		// infinity regardless of the explicit one
		send_request(make_request(FMT_EXT, FMT_SINGLE, 64'h0, 16'h7fff));
		send_request(make_request(FMT_EXT, FMT_DOUBLE, 64'h8000_0000_0000_0000, 16'hffff));
		send_request(make_request(FMT_EXT, FMT_EXT, 64'hc000_0000_0000_0000, 16'h7fff));
		send_request(make_request(FMT_EXT, FMT_SINGLE, 64'hffff_ffff_ffff_ff00, 16'hffff));
		send_request(make_request(FMT_EXT, FMT_EXT, 64'hffff_ffff_ffff_ffff, 16'h7ffe));
		send_request(make_request(FMT_EXT, FMT_DOUBLE, 64'hffff_ffff_ffff_ffff, 16'hfffe));
		send_request(make_request(FMT_EXT, FMT_EXT, 64'h8000_0000_0000_0000, 16'h0001));
		send_request(make_request(FMT_EXT_ALT, FMT_EXT_ALT, 64'h8000_0000_0000_0000, 16'h3fff));
		send_request(make_request(FMT_DOUBLE, FMT_EXT_ALT, 64'h3ff0_0000_0000_0000, 16'h0));

		for (int phase = 0; phase < 4; phase++) begin
			steady = (phase == 2);
			repeat (400)
				send_request(random_request());
		end
		src_valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
